[src/scm_pkg.sv]
// Shared types, constants and range checks for the stack machine interpreter.
`timescale 1ns / 1ps
package scm_pkg;

   localparam int CODE_DEPTH  = 1024;
   localparam int STACK_DEPTH = 512;
   localparam int CODE_AW     = $clog2(CODE_DEPTH);
   localparam int STACK_AW    = $clog2(STACK_DEPTH);
   localparam int TOP_W       = $clog2(STACK_DEPTH + 1);
   localparam int WORD_W      = 32;
   localparam int CALC_W      = WORD_W + 2;
   localparam int PCO_W       = 10;

   localparam logic signed [CALC_W-1:0] STACK_LIM = CALC_W'(STACK_DEPTH);
   localparam logic signed [CALC_W-1:0] CODE_LIM  = CALC_W'(CODE_DEPTH);

   localparam logic [1:0] CMD_LOAD    = 2'd0;
   localparam logic [1:0] CMD_EXEC    = 2'd1;
   localparam logic [1:0] CMD_RESTART = 2'd2;

   localparam logic [3:0] OP_LIT = 4'd0;
   localparam logic [3:0] OP_RET = 4'd1;
   localparam logic [3:0] OP_LOD = 4'd2;
   localparam logic [3:0] OP_STO = 4'd3;
   localparam logic [3:0] OP_CAL = 4'd4;
   localparam logic [3:0] OP_INT = 4'd5;
   localparam logic [3:0] OP_JMP = 4'd6;
   localparam logic [3:0] OP_JPC = 4'd7;
   localparam logic [3:0] OP_RED = 4'd8;
   localparam logic [3:0] OP_WRT = 4'd9;
   localparam logic [3:0] OP_ADD = 4'd10;
   localparam logic [3:0] OP_SUB = 4'd11;
   localparam logic [3:0] OP_DIV = 4'd12;
   localparam logic [3:0] OP_MUL = 4'd13;

   localparam logic [1:0] FAULT_NONE  = 2'd0;
   localparam logic [1:0] FAULT_DIV   = 2'd1;
   localparam logic [1:0] FAULT_STACK = 2'd2;
   localparam logic [1:0] FAULT_CODE  = 2'd3;

   typedef struct packed {
      logic [1:0]        command;
      logic [9:0]        load_address;
      logic [3:0]        load_opcode;
      logic              load_level;
      logic [WORD_W-1:0] load_operand;
      logic [WORD_W-1:0] read_value;
   } req_type;

   typedef struct packed {
      logic              write_valid;
      logic [WORD_W-1:0] write_value;
      logic              halted;
      logic [1:0]        fault;
      logic [PCO_W-1:0]  program_counter;
   } rsp_type;

   typedef struct packed {
      logic [3:0]        opcode;
      logic              level;
      logic [WORD_W-1:0] operand;
   } code_word_type;

   localparam int CODE_W = $bits(code_word_type);

   typedef enum logic [2:0] {
      S_CLR,
      S_IDLE,
      S_OPER,
      S_EXEC,
      S_CAL2,
      S_DIV,
      S_EMIT
   } state_type;

   function automatic logic in_stack(input logic signed [CALC_W-1:0] v);
      in_stack = (v >= 0) && (v < STACK_LIM);
   endfunction

   function automatic logic in_code(input logic signed [CALC_W-1:0] v);
      in_code = (v >= 0) && (v < CODE_LIM);
   endfunction

endpackage

[src/scm_ram.sv]
// Generic synchronous RAM: one write port, two registered read ports.
`timescale 1ns / 1ps
module scm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re0,
   input  logic [$clog2(DEPTH)-1:0] raddr0,
   output logic [WIDTH-1:0]         rdata0,
   input  logic                     re1,
   input  logic [$clog2(DEPTH)-1:0] raddr1,
   output logic [WIDTH-1:0]         rdata1
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re0) begin
         rdata0 <= mem_ff[raddr0];
      end
      if (re1) begin
         rdata1 <= mem_ff[raddr1];
      end
   end

endmodule

[src/scm_div.sv]
// Signed 32-bit restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module scm_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [scm_pkg::WORD_W-1:0] dividend,
   input  logic [scm_pkg::WORD_W-1:0] divisor,
   output logic                      done,
   output logic [scm_pkg::WORD_W-1:0] quotient
);
   import scm_pkg::*;

   localparam int CNT_W = $clog2(WORD_W);

   logic [WORD_W-1:0] den_ff, den_in, quo_ff, quo_in, rem_ff, rem_in;
   logic              neg_ff, neg_in, busy_ff, busy_in, done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [WORD_W:0]   rem_sh, den_ext;
   logic              ge;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[WORD_W-1]};
      den_ext = {1'b0, den_ff};
      ge      = rem_sh >= den_ext;
      den_in  = den_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         den_in  = divisor[WORD_W-1] ? -divisor : divisor;
         quo_in  = dividend[WORD_W-1] ? -dividend : dividend;
         rem_in  = '0;
         neg_in  = dividend[WORD_W-1] ^ divisor[WORD_W-1];
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (busy_ff) begin
         rem_in = ge ? WORD_W'(rem_sh - den_ext) : WORD_W'(rem_sh);
         quo_in = {quo_ff[WORD_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(WORD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      den_ff <= den_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -quo_ff : quo_ff;

endmodule

[src/stack_machine_interpreter.sv]
// P-code stack machine interpreter top level.
// A load or an ignored command goes from accept straight to the result state, an executed
// instruction steps through code fetch, stack read, execute and write back, and result, a cal
// adds a second stack write state, since its two stack writes share the single stack write
// port, and a div waits on the 32-step bit-serial divider. A restart clears stack slots 0 to 2,
// one per cycle. After reset the block stalls its input while it clears the stack memory one
// slot per cycle. One word is worked on at a time; a finished result waits in the output
// register while the next word is accepted.
`timescale 1ns / 1ps
module stack_machine_interpreter (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  scm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output scm_pkg::rsp_type rsp_data
);
   import scm_pkg::*;

   state_type state_ff, state_in;

   logic [CODE_AW-1:0]  pc_ff, pc_in;
   logic [STACK_AW-1:0] base_ff, base_in;
   logic [TOP_W-1:0]    top_ff, top_in;
   logic                first_ff, first_in, halt_ff, halt_in;
   logic [STACK_AW-1:0] clr_cnt_ff, clr_cnt_in, clr_last_ff, clr_last_in;
   logic                clr_emit_ff, clr_emit_in;
   logic [WORD_W-1:0]   red_ff, red_in;
   logic [1:0]          res_fault_ff, res_fault_in;
   logic                res_wv_ff, res_wv_in;
   logic [WORD_W-1:0]   res_wval_ff, res_wval_in;
   logic [STACK_AW-1:0] pend_addr_ff, pend_addr_in;
   logic [WORD_W-1:0]   pend_data_ff, pend_data_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic                code_we, code_re;
   logic [CODE_AW-1:0]  code_waddr;
   code_word_type       code_wdata, cw;
   logic [CODE_W-1:0]   code_q;

   logic                stk_we, stk_re;
   logic [STACK_AW-1:0] stk_waddr, stk_raddr0, stk_raddr1;
   logic [WORD_W-1:0]   stk_wdata, rd0, rd1;

   logic                div_start, div_done;
   logic [WORD_W-1:0]   div_q;

   logic                take, load_oob, emit_go;
   logic signed [CALC_W-1:0] sa, sb, st, sp, addr, sd0, sd1, np, nt, nb, ridx0, ridx1, widx;
   logic                ex_fstack, ex_ok, ex_wr, div_zero;
   logic [1:0]          ex_fault;
   logic [WORD_W-1:0]   ex_wdata, prod;

   scm_ram #(.WIDTH(CODE_W), .DEPTH(CODE_DEPTH)) u_code_ram (
      .clock  (clock),
      .we     (code_we),
      .waddr  (code_waddr),
      .wdata  (code_wdata),
      .re0    (code_re),
      .raddr0 (pc_ff),
      .rdata0 (code_q),
      .re1    (1'b0),
      .raddr1 ('0),
      .rdata1 ()
   );

   scm_ram #(.WIDTH(WORD_W), .DEPTH(STACK_DEPTH)) u_stack_ram (
      .clock  (clock),
      .we     (stk_we),
      .waddr  (stk_waddr),
      .wdata  (stk_wdata),
      .re0    (stk_re),
      .raddr0 (stk_raddr0),
      .rdata0 (rd0),
      .re1    (stk_re),
      .raddr1 (stk_raddr1),
      .rdata1 (rd1)
   );

   scm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (rd0),
      .divisor  (rd1),
      .done     (div_done),
      .quotient (div_q)
   );

   assign take     = (state_ff == S_IDLE) && req_valid;
   assign load_oob = 32'(req_data.load_address) >= 32'(CODE_DEPTH);
   assign emit_go  = (state_ff == S_EMIT) && (!rsp_valid_ff || !rsp_stall);
   assign cw       = code_word_type'(code_q);
   assign div_zero = rd1 == '0;
   assign prod     = rd0 * rd1;

   // decode and execute
   always_comb begin
      sa  = $signed(cw.operand);
      sb  = CALC_W'(base_ff);
      st  = CALC_W'(top_ff);
      sp  = CALC_W'(pc_ff);
      sd0 = $signed(rd0);
      sd1 = $signed(rd1);
      addr = cw.level ? sa : sa + sb;
      np  = sp + 1;
      nt  = st;
      nb  = sb;
      ex_fstack = 1'b0;
      ex_wr     = 1'b0;
      ex_wdata  = rd0;
      widx      = st;
      ridx0     = st - 1;
      ridx1     = st - 1;
      unique case (cw.opcode)
         OP_LIT: begin
            ex_fstack = !(st < STACK_LIM);
            ex_wr     = 1'b1;
            ex_wdata  = cw.operand;
            nt        = st + 1;
         end
         OP_RED: begin
            ex_fstack = !(st < STACK_LIM);
            ex_wr     = 1'b1;
            ex_wdata  = red_ff;
            nt        = st + 1;
         end
         OP_RET: begin
            ridx0     = sb;
            ridx1     = sb + 1;
            ex_fstack = !in_stack(sb + 1) || !in_stack(sd0);
            nt        = sb;
            nb        = sd0;
            np        = sd1;
         end
         OP_LOD: begin
            ridx0     = addr;
            ex_fstack = !(st < STACK_LIM) || !in_stack(addr);
            ex_wr     = 1'b1;
            nt        = st + 1;
         end
         OP_STO: begin
            ex_fstack = (st < 1) || !in_stack(addr);
            ex_wr     = 1'b1;
            widx      = addr;
            nt        = st - 1;
         end
         OP_CAL: begin
            ex_fstack = !in_stack(st + 1);
            ex_wr     = 1'b1;
            ex_wdata  = WORD_W'(base_ff);
            nb        = st;
            np        = sa;
         end
         OP_INT: begin
            nt        = st + sa;
            ex_fstack = (nt < 0) || (nt > STACK_LIM);
         end
         OP_JMP: begin
            np = sa;
         end
         OP_JPC: begin
            ex_fstack = st < 1;
            nt        = st - 1;
            if (rd0 == '0) begin
               np = sa;
            end
         end
         OP_WRT: begin
            ex_fstack = st < 1;
            nt        = st - 1;
         end
         OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
            ridx0     = st - 2;
            ex_fstack = st < 2;
            widx      = st - 2;
            nt        = st - 1;
            ex_wr     = (cw.opcode != OP_DIV) || div_zero;
            unique case (cw.opcode)
               OP_ADD:  ex_wdata = rd0 + rd1;
               OP_SUB:  ex_wdata = rd0 - rd1;
               OP_MUL:  ex_wdata = prod;
               default: ex_wdata = '0;
            endcase
         end
         default: begin
         end
      endcase
      if (ex_fstack) begin
         ex_fault = FAULT_STACK;
      end else if (!in_code(np)) begin
         ex_fault = FAULT_CODE;
      end else if ((cw.opcode == OP_DIV) && div_zero) begin
         ex_fault = FAULT_DIV;
      end else begin
         ex_fault = FAULT_NONE;
      end
      ex_ok = (ex_fault == FAULT_NONE) || (ex_fault == FAULT_DIV);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLR: begin
            if (clr_cnt_ff == clr_last_ff) begin
               state_in = clr_emit_ff ? S_EMIT : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               if (req_data.command == CMD_RESTART) begin
                  state_in = S_CLR;
               end else if ((req_data.command == CMD_EXEC) && !halt_ff) begin
                  state_in = S_OPER;
               end else begin
                  state_in = S_EMIT;
               end
            end
         end
         S_OPER: state_in = S_EXEC;
         S_EXEC: begin
            if (!ex_ok) begin
               state_in = S_EMIT;
            end else if (cw.opcode == OP_CAL) begin
               state_in = S_CAL2;
            end else if ((cw.opcode == OP_DIV) && !div_zero) begin
               state_in = S_DIV;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_CAL2: state_in = S_EMIT;
         S_DIV: begin
            if (div_done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (emit_go) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // memory and unit controls
   always_comb begin
      req_stall  = state_ff != S_IDLE;
      code_we    = take && (req_data.command == CMD_LOAD) && !load_oob;
      code_waddr = CODE_AW'(req_data.load_address);
      code_wdata = '{opcode:  req_data.load_opcode,
                     level:   req_data.load_level,
                     operand: req_data.load_operand};
      code_re    = take && (req_data.command == CMD_EXEC) && !halt_ff;
      stk_re     = state_ff == S_OPER;
      stk_raddr0 = ridx0[STACK_AW-1:0];
      stk_raddr1 = ridx1[STACK_AW-1:0];
      div_start  = (state_ff == S_EXEC) && ex_ok && (cw.opcode == OP_DIV) && !div_zero;
      stk_we     = 1'b0;
      stk_waddr  = widx[STACK_AW-1:0];
      stk_wdata  = ex_wdata;
      unique case (state_ff)
         S_CLR: begin
            stk_we    = 1'b1;
            stk_waddr = clr_cnt_ff;
            stk_wdata = '0;
         end
         S_EXEC: stk_we = ex_ok && ex_wr;
         S_CAL2: begin
            stk_we    = 1'b1;
            stk_waddr = pend_addr_ff;
            stk_wdata = pend_data_ff;
         end
         S_DIV: begin
            stk_we    = div_done;
            stk_waddr = pend_addr_ff;
            stk_wdata = div_q;
         end
         default: begin
         end
      endcase
   end

   // machine registers and result
   always_comb begin
      pc_in        = pc_ff;
      base_in      = base_ff;
      top_in       = top_ff;
      first_in     = first_ff;
      halt_in      = halt_ff;
      clr_cnt_in   = clr_cnt_ff;
      clr_last_in  = clr_last_ff;
      clr_emit_in  = clr_emit_ff;
      red_in       = red_ff;
      res_fault_in = res_fault_ff;
      res_wv_in    = res_wv_ff;
      res_wval_in  = res_wval_ff;
      pend_addr_in = pend_addr_ff;
      pend_data_in = pend_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         S_CLR: clr_cnt_in = clr_cnt_ff + 1'b1;
         S_IDLE: begin
            if (req_valid) begin
               red_in       = req_data.read_value;
               res_wv_in    = 1'b0;
               res_wval_in  = '0;
               res_fault_in = ((req_data.command == CMD_LOAD) && load_oob) ?
                              FAULT_CODE : FAULT_NONE;
               if (req_data.command == CMD_RESTART) begin
                  pc_in       = '0;
                  base_in     = '0;
                  top_in      = '0;
                  first_in    = 1'b0;
                  halt_in     = 1'b0;
                  clr_cnt_in  = '0;
                  clr_last_in = STACK_AW'(2);
                  clr_emit_in = 1'b1;
               end
            end
         end
         S_EXEC: begin
            res_fault_in = ex_fault;
            res_wv_in    = ex_ok && (cw.opcode == OP_WRT);
            res_wval_in  = (ex_ok && (cw.opcode == OP_WRT)) ? rd0 : '0;
            pend_addr_in = (cw.opcode == OP_CAL) ? STACK_AW'(st + 1) : STACK_AW'(st - 2);
            pend_data_in = first_ff ? WORD_W'(pc_ff) + WORD_W'(1) : '0;
            if (ex_ok) begin
               pc_in   = np[CODE_AW-1:0];
               base_in = nb[STACK_AW-1:0];
               top_in  = nt[TOP_W-1:0];
               halt_in = halt_ff || (np == 0);
               if (cw.opcode == OP_CAL) begin
                  first_in = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      if (emit_go) begin
         rsp_valid_in = 1'b1;
         rsp_in = '{write_valid:     res_wv_ff,
                    write_value:     res_wval_ff,
                    halted:          halt_ff,
                    fault:           res_fault_ff,
                    program_counter: PCO_W'(pc_ff)};
      end
   end

   always_ff @(posedge clock) begin
      red_ff       <= red_in;
      res_fault_ff <= res_fault_in;
      res_wv_ff    <= res_wv_in;
      res_wval_ff  <= res_wval_in;
      pend_addr_ff <= pend_addr_in;
      pend_data_ff <= pend_data_in;
      rsp_ff       <= rsp_in;
      if (reset) begin
         state_ff     <= S_CLR;
         pc_ff        <= '0;
         base_ff      <= '0;
         top_ff       <= '0;
         first_ff     <= 1'b0;
         halt_ff      <= 1'b0;
         clr_cnt_ff   <= '0;
         clr_last_ff  <= STACK_AW'(STACK_DEPTH - 1);
         clr_emit_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         base_ff      <= base_in;
         top_ff       <= top_in;
         first_ff     <= first_in;
         halt_ff      <= halt_in;
         clr_cnt_ff   <= clr_cnt_in;
         clr_last_ff  <= clr_last_in;
         clr_emit_ff  <= clr_emit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !stk_we)
      else $error("stack written while idle");

   a_top_range: assert property (@(posedge clock) disable iff (reset)
      top_ff <= TOP_W'(STACK_DEPTH))
      else $error("top beyond stack depth");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_EMIT))
      else $error("result word raised outside emit");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV))
      else $error("divider finished outside divide state");

   a_halt_pc: assert property (@(posedge clock) disable iff (reset)
      halt_ff |-> (pc_ff == '0))
      else $error("halted with nonzero program counter");
`endif

endmodule
